// ===== hw/rtl/shortest_job_first_scheduler_defines.svh =====
// Assertion helpers for the scheduler
`ifndef SHORTEST_JOB_FIRST_SCHEDULER_DEFINES_SVH
`define SHORTEST_JOB_FIRST_SCHEDULER_DEFINES_SVH

// assert that a implies b at the same edge
`define SJF_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// assert that a implies b at the next edge
`define SJF_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ===== hw/rtl/sjf_pkg.sv =====
// ----------------------------------------------------------------------------
// sjf_pkg
// Types and codes shared by the scheduler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sjf_pkg;
    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_DISPATCH = 2'd1,
        CMD_REINSERT = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_INSERTED   = 3'd0,
        KIND_FINISHED   = 3'd1,
        KIND_BLOCKED    = 3'd2,
        KIND_REINSERTED = 3'd3,
        KIND_EMPTY      = 3'd4,
        KIND_READY_FULL = 3'd5,
        KIND_BLOCK_LOST = 3'd6
    } t_kind;

    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] burst;
        logic       block_req;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_PICK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_APPEND,
        ST_DONE
    } t_state;
endpackage

// ===== hw/rtl/sjf_ram.sv =====
// ----------------------------------------------------------------------------
// sjf_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sjf_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/sjf_front.sv =====
// ----------------------------------------------------------------------------
// sjf_front
// Takes commands, drops unused codes and holds a two-word command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sjf_front import sjf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_job i_job,
    output logic o_busy,
    output logic o_empty,
    output t_job o_job,
    input  logic i_pop
);
    t_job       r_q [2];
    logic       r_rd_ptr, r_wr_ptr;
    logic [1:0] r_cnt;
    logic       push;

    assign o_busy  = (r_cnt == 2'd2);
    assign push    = i_start && !o_busy && (i_job.cmd != CMD_NONE);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= i_job;
        end
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule

// ===== hw/rtl/sjf_back.sv =====
// ----------------------------------------------------------------------------
// sjf_back
// Runs one command, issuing one result: insert appends to ready; dispatch or
// reinsert finds the shortest, closes the gap, may move it to the other table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sjf_back import sjf_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [3:0]  i_slice,
    input  logic        i_have,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_valid,
    output t_kind       o_kind,
    output logic [15:0] o_id,
    output logic [3:0]  o_time
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = ID_BITS + 4;

    t_state r_st, n_st;
    t_job   r_job;
    logic [CW-1:0] r_rcnt, r_bcnt;
    logic [ID_BITS-1:0] r_next_id;
    logic [CW-1:0] r_i;              // scan / shift index
    logic [AW-1:0] r_best;
    logic [3:0]    r_btime;
    logic [ID_BITS-1:0] r_bid;
    logic          r_src;            // 0 ready, 1 blocked table scanned
    t_kind         r_kind;
    logic [3:0]    r_time;

    // ram ports
    logic          r_we, b_we;
    logic [AW-1:0] r_wa, b_wa, ra;
    logic [DW-1:0] r_wd, b_wd, r_rd, b_rd, rd;

    sjf_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_ready (
        .i_clk(i_clk), .i_we(r_we), .i_waddr(r_wa), .i_wdata(r_wd),
        .i_raddr(ra), .o_rdata(r_rd));
    sjf_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_blocked (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_wa), .i_wdata(b_wd),
        .i_raddr(ra), .o_rdata(b_rd));

    logic [CW-1:0] scnt;
    logic          rfull, bfull;
    logic          will_block;
    logic [3:0]    sub_time;

    assign rd         = r_src ? b_rd : r_rd;
    assign scnt       = r_src ? r_bcnt : r_rcnt;
    assign rfull      = (r_rcnt == CW'(QUEUE_DEPTH));
    assign bfull      = (r_bcnt == CW'(QUEUE_DEPTH));
    assign will_block = r_job.block_req && (r_btime > i_slice);
    assign sub_time   = r_btime - i_slice;
    assign ra         = r_i[AW-1:0];

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:   if (i_have) n_st = ST_DECIDE;
            ST_DECIDE: begin
                unique case (r_job.cmd)
                    CMD_INSERT:   n_st = rfull ? ST_DONE : ST_APPEND;
                    CMD_DISPATCH: n_st = (r_rcnt == '0) ? ST_DONE : ST_SCAN_RD;
                    CMD_REINSERT: n_st = (r_bcnt == '0) ? ST_DONE : ST_SCAN_RD;
                    default:      n_st = ST_DONE;
                endcase
            end
            ST_SCAN_RD: n_st = ST_SCAN;
            // rd holds entry r_i-1, so the last entry is seen at r_i == count
            ST_SCAN:    n_st = (r_i >= scnt) ? ST_PICK : ST_SCAN;
            ST_PICK: begin
                if (r_src && rfull) n_st = ST_DONE;
                else if (CW'(r_best) + 1'b1 < scnt) n_st = ST_SHIFT_RD;
                else n_st = ST_APPEND;
            end
            ST_SHIFT_RD: n_st = ST_SHIFT_WR;
            ST_SHIFT_WR: n_st = (r_i + 1'b1 >= scnt) ? ST_APPEND : ST_SHIFT_RD;
            ST_APPEND:   n_st = ST_DONE;
            ST_DONE:     n_st = ST_IDLE;
            default:     n_st = ST_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        o_pop = (r_st == ST_IDLE) && i_have;
        r_we = 1'b0; b_we = 1'b0;
        r_wa = '0;   b_wa = '0;
        r_wd = '0;   b_wd = '0;
        o_valid = (r_st == ST_DONE);
        o_kind  = r_kind;
        o_id    = 16'(r_bid);
        o_time  = r_time;
        unique case (r_st)
            ST_SHIFT_WR: begin
                // entry r_i moves down to r_i-1
                r_we = !r_src; b_we = r_src;
                r_wa = AW'(r_i - 1'b1); b_wa = AW'(r_i - 1'b1);
                r_wd = rd; b_wd = rd;
            end
            ST_APPEND: begin
                if (r_job.cmd == CMD_INSERT || r_src) begin
                    r_we = 1'b1;
                    r_wa = r_rcnt[AW-1:0];
                    r_wd = {r_bid, r_time};
                end else if (r_kind == KIND_BLOCKED) begin
                    b_we = 1'b1;
                    b_wa = r_bcnt[AW-1:0];
                    b_wd = {r_bid, r_time};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_rcnt    <= '0;
            r_bcnt    <= '0;
            r_next_id <= ID_BITS'(1);
        end else begin
            r_st <= n_st;
            if (r_st == ST_APPEND) begin
                if (r_job.cmd == CMD_INSERT) begin
                    r_rcnt <= r_rcnt + 1'b1;
                    r_next_id <= (r_next_id == '1) ? ID_BITS'(1) : r_next_id + 1'b1;
                end else if (r_src) begin
                    r_rcnt <= r_rcnt + 1'b1;
                    r_bcnt <= r_bcnt - 1'b1;
                end else begin
                    r_rcnt <= r_rcnt - 1'b1;
                    if (r_kind == KIND_BLOCKED) r_bcnt <= r_bcnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: begin
                r_job <= i_job;
                r_src <= (i_job.cmd == CMD_REINSERT);
            end
            ST_DECIDE: begin
                r_i    <= '0;
                r_best <= '0;
                r_btime <= 4'hF;
                r_bid  <= '0;
                r_time <= '0;
                if (r_job.cmd == CMD_INSERT) begin
                    if (rfull) begin
                        r_kind <= KIND_READY_FULL;
                    end else begin
                        r_kind <= KIND_INSERTED;
                        r_bid  <= r_next_id;
                        r_time <= r_job.burst;
                    end
                end else begin
                    r_kind <= KIND_EMPTY;
                end
            end
            ST_SCAN_RD: r_i <= r_i + 1'b1;
            ST_SCAN: begin
                // rd holds entry r_i-1; strict < keeps earliest on ties
                if (r_i == CW'(1) || rd[3:0] < r_btime) begin
                    r_best  <= AW'(r_i - 1'b1);
                    r_btime <= rd[3:0];
                    r_bid   <= rd[DW-1:4];
                end
                r_i <= r_i + 1'b1;
            end
            ST_PICK: begin
                r_i <= CW'(r_best) + 1'b1;
                if (r_src) begin
                    r_kind <= rfull ? KIND_READY_FULL : KIND_REINSERTED;
                    r_time <= r_btime;
                end else if (will_block) begin
                    r_kind <= bfull ? KIND_BLOCK_LOST : KIND_BLOCKED;
                    r_time <= sub_time;
                end else begin
                    r_kind <= KIND_FINISHED;
                    r_time <= r_btime;
                end
            end
            ST_SHIFT_WR: r_i <= r_i + 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/shortest_job_first_scheduler.sv =====
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler
// Ready / blocked process tables with shortest-time dispatch.
// ----------------------------------------------------------------------------
// A dispatch or reinsert scans the N table entries one per cycle through the
// table RAM read port, then copies the M entries behind the chosen one down,
// each with a read state and a write state. Commands go into a two-word
// queue; busy is high only while it is full. Each result is shown for one
// cycle with o_valid and must be taken then: the receiver cannot stall.
// Unused code 3 is dropped.
`timescale 1ns / 1ps
`include "shortest_job_first_scheduler_defines.svh"
module shortest_job_first_scheduler import sjf_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_burst_time,
    input  logic        i_block_request,
    input  logic        i_slice_we,
    input  logic [3:0]  i_slice_wdata,
    output logic        o_valid,
    output logic [2:0]  o_result_kind,
    output logic [15:0] o_proc_id,
    output logic [3:0]  o_time_left
);
    logic [3:0] r_slice;
    t_job  in_job, q_job;
    logic  q_empty, pop;
    t_kind kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice <= 4'd2;
        end else if (i_slice_we) begin
            r_slice <= i_slice_wdata;
        end
    end

    assign in_job = '{cmd: t_cmd'(i_cmd), burst: i_burst_time, block_req: i_block_request};

    sjf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_job(in_job),
        .o_busy(busy), .o_empty(q_empty), .o_job(q_job), .i_pop(pop));

    sjf_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_slice(r_slice),
        .i_have(!q_empty), .i_job(q_job), .o_pop(pop),
        .o_valid(o_valid), .o_kind(kind), .o_id(o_proc_id), .o_time(o_time_left));

    assign o_result_kind = kind;

    `SJF_ASSERT_NEXT(a_valid_one, i_clk, i_rst_n, o_valid, !o_valid, "result held twice")
    `SJF_ASSERT_IMPL(a_none_zero, i_clk, i_rst_n, o_valid && kind == KIND_EMPTY, o_proc_id == 16'd0 && o_time_left == 4'd0, "empty result carries data")
    `SJF_ASSERT_IMPL(a_ins_id, i_clk, i_rst_n, o_valid && kind == KIND_INSERTED, o_proc_id != 16'd0 || ID_BITS > 16, "inserted id zero")
endmodule

// ===== dv/shortest_job_first_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler_tb
// Drives scheduler commands under random start gaps. A shadow copy of the
// ready and blocked tables predicts each result, and the testbench checks
// the results in order. Several slice settings are run, including 0 and 15.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module shortest_job_first_scheduler_tb;
    import sjf_pkg::*;

    localparam int DEPTH       = 16;
    localparam int DRAIN_WAIT  = 400;

    typedef struct {
        t_cmd       cmd;
        logic [3:0] burst;
        logic       blk;
    } t_cmd_word;

    typedef struct {
        t_kind       kind;
        logic [15:0] id;
        logic [3:0]  tl;
    } t_sched_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [3:0]  i_burst_time;
    logic        i_block_request;
    logic        i_slice_we;
    logic [3:0]  i_slice_wdata;
    logic        o_valid;
    logic [2:0]  o_result_kind;
    logic [15:0] o_proc_id;
    logic [3:0]  o_time_left;

    shortest_job_first_scheduler u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_burst_time   (i_burst_time),
        .i_block_request(i_block_request),
        .i_slice_we     (i_slice_we),
        .i_slice_wdata  (i_slice_wdata),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_proc_id      (o_proc_id),
        .o_time_left    (o_time_left)
    );

    // shadow tables
    logic [15:0] rdy_id [DEPTH];
    logic [3:0]  rdy_t  [DEPTH];
    int          rdy_n;
    logic [15:0] blk_id [DEPTH];
    logic [3:0]  blk_t  [DEPTH];
    int          blk_n;
    logic [15:0] id_next;
    logic [3:0]  slice_len;

    t_cmd_word     cmd_q [$];
    t_sched_result result_q [$];
    int            gap_pct;
    int            n_err;
    int            n_checked;
    int            kind_seen [8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int shortest_pos(ref logic [3:0] t [DEPTH], input int n);
        int best;
        best = 0;
        for (int i = 1; i < n; i++) begin
            if (t[i] < t[best]) best = i;
        end
        return best;
    endfunction

    task automatic schedule_cmd(input t_cmd_word w);
        t_sched_result r;
        int            p;
        logic [15:0]   id;
        logic [3:0]    t;
        r = '{KIND_EMPTY, 16'd0, 4'd0};
        case (w.cmd)
            CMD_INSERT: begin
                if (rdy_n >= DEPTH) begin
                    r.kind = KIND_READY_FULL;
                end else begin
                    rdy_id[rdy_n] = id_next;
                    rdy_t[rdy_n]  = w.burst;
                    rdy_n++;
                    r = '{KIND_INSERTED, id_next, w.burst};
                    id_next++;
                    if (id_next == 16'd0) begin
                        id_next = 16'd1;
                    end
                end
            end
            CMD_DISPATCH: begin
                if (rdy_n != 0) begin
                    p  = shortest_pos(rdy_t, rdy_n);
                    id = rdy_id[p];
                    t  = rdy_t[p];
                    for (int i = p; i + 1 < rdy_n; i++) begin
                        rdy_id[i] = rdy_id[i+1];
                        rdy_t[i]  = rdy_t[i+1];
                    end
                    rdy_n--;
                    if (w.blk && t > slice_len) begin
                        t = t - slice_len;
                        if (blk_n >= DEPTH) begin
                            r = '{KIND_BLOCK_LOST, id, t};
                        end else begin
                            blk_id[blk_n] = id;
                            blk_t[blk_n]  = t;
                            blk_n++;
                            r = '{KIND_BLOCKED, id, t};
                        end
                    end else begin
                        r = '{KIND_FINISHED, id, t};
                    end
                end
            end
            CMD_REINSERT: begin
                if (blk_n != 0) begin
                    p  = shortest_pos(blk_t, blk_n);
                    id = blk_id[p];
                    t  = blk_t[p];
                    if (rdy_n >= DEPTH) begin
                        r = '{KIND_READY_FULL, id, t};
                    end else begin
                        for (int i = p; i + 1 < blk_n; i++) begin
                            blk_id[i] = blk_id[i+1];
                            blk_t[i]  = blk_t[i+1];
                        end
                        blk_n--;
                        rdy_id[rdy_n] = id;
                        rdy_t[rdy_n]  = t;
                        rdy_n++;
                        r = '{KIND_REINSERTED, id, t};
                    end
                end
            end
            default: return; // unused code, no result
        endcase
        result_q.push_back(r);
    endtask

    // driver: a word is taken when start is high and busy low at the edge
    always @(posedge i_clk) begin
        t_cmd_word w;
        logic      go;
        if (!i_rst_n) begin
            start           <= 1'b0;
            i_cmd           <= CMD_NONE;
            i_burst_time    <= 4'd0;
            i_block_request <= 1'b0;
        end else begin
            go = start;
            if (start && !busy) begin
                schedule_cmd('{t_cmd'(i_cmd), i_burst_time, i_block_request});
                go = 1'b0;
            end
            if (!go && cmd_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                w               = cmd_q.pop_front();
                i_cmd           <= w.cmd;
                i_burst_time    <= w.burst;
                i_block_request <= w.blk;
                go              = 1'b1;
            end
            start <= go;
        end
    end

    // monitor: results cannot be held off, each one is checked when seen
    always @(posedge i_clk) begin
        t_sched_result e;
        if (i_rst_n && o_valid) begin
            if (result_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: unexpected result kind=%0d id=%0d time=%0d",
                             o_result_kind, o_proc_id, o_time_left);
            end else begin
                e = result_q.pop_front();
                n_checked++;
                kind_seen[o_result_kind]++;
                if (o_result_kind !== e.kind || o_proc_id !== e.id
                    || o_time_left !== e.tl) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: exp kind=%0d id=%0d time=%0d, got %0d %0d %0d",
                                 e.kind, e.id, e.tl, o_result_kind, o_proc_id,
                                 o_time_left);
                end
            end
        end
    end

    task automatic push_cmd(input t_cmd c, input logic [3:0] b, input logic k);
        cmd_q.push_back('{c, b, k});
    endtask

    task automatic drain();
        while (cmd_q.size() != 0 || start || result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_slice(input logic [3:0] v);
        @(posedge i_clk);
        i_slice_we    <= 1'b1;
        i_slice_wdata <= v;
        @(posedge i_clk);
        i_slice_we <= 1'b0;
        slice_len = v;
    endtask

    // groups of 20 words lean toward one command, or mix, so the tables fill and empty
    task automatic random_words(input int count);
        int   lean;
        int   roll;
        t_cmd c;
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0) lean = $urandom_range(3);
            roll = $urandom_range(99);
            if (roll < 3) c = CMD_NONE;
            else if (lean == 0) c = (roll < 75) ? CMD_INSERT : (roll < 90) ? CMD_DISPATCH
                                                                          : CMD_REINSERT;
            else if (lean == 1) c = (roll < 20) ? CMD_INSERT : (roll < 85) ? CMD_DISPATCH
                                                                          : CMD_REINSERT;
            else if (lean == 2) c = (roll < 20) ? CMD_INSERT : (roll < 40) ? CMD_DISPATCH
                                                                          : CMD_REINSERT;
            else c = (roll < 40) ? CMD_INSERT : (roll < 70) ? CMD_DISPATCH : CMD_REINSERT;
            push_cmd(c, 4'($urandom_range(15)), ($urandom_range(99) < 70));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_slice_we    = 1'b0;
        i_slice_wdata = 4'd0;
        rdy_n = 0; blk_n = 0; id_next = 16'd1; slice_len = 4'd2;
        n_err = 0; n_checked = 0;
        gap_pct = 8;
        foreach (kind_seen[k]) kind_seen[k] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty tables, unused code, extremes, reset slice of 2
        push_cmd(CMD_DISPATCH, 4'd0, 1'b0);
        push_cmd(CMD_REINSERT, 4'd0, 1'b0);
        push_cmd(CMD_NONE, 4'd15, 1'b1);
        push_cmd(CMD_INSERT, 4'd15, 1'b0);
        push_cmd(CMD_INSERT, 4'd0, 1'b0);
        push_cmd(CMD_INSERT, 4'd2, 1'b0);
        push_cmd(CMD_INSERT, 4'd15, 1'b1);
        push_cmd(CMD_DISPATCH, 4'd0, 1'b1);   // time 0 cannot block
        push_cmd(CMD_DISPATCH, 4'd0, 1'b1);   // equal to slice, finishes
        push_cmd(CMD_DISPATCH, 4'd0, 1'b1);   // tie, earliest goes and blocks
        push_cmd(CMD_REINSERT, 4'd0, 1'b0);
        push_cmd(CMD_DISPATCH, 4'd0, 1'b0);
        push_cmd(CMD_DISPATCH, 4'd0, 1'b0);
        drain();

        // zero slice: blocked time unchanged; fill both tables to the brim
        write_slice(4'd0);
        for (int i = 0; i < 17; i++) push_cmd(CMD_INSERT, 4'(i % 16 | 1), 1'b0);
        for (int i = 0; i < 17; i++) push_cmd(CMD_DISPATCH, 4'd0, 1'b1);
        for (int i = 0; i < 17; i++) push_cmd(CMD_INSERT, 4'd15, 1'b0);
        push_cmd(CMD_REINSERT, 4'd0, 1'b0);   // ready full, entry stays blocked
        push_cmd(CMD_DISPATCH, 4'd0, 1'b1);   // blocked full, process lost
        drain();

        write_slice(4'd15);
        random_words(130);
        drain();

        gap_pct = 46;
        write_slice(4'd1);
        random_words(140);
        drain();

        gap_pct = 0;
        write_slice(4'($urandom_range(3, 9)));
        random_words(130);
        drain();

        // empty both tables at the end
        for (int i = 0; i < 20; i++) push_cmd(CMD_DISPATCH, 4'd0, 1'b0);
        for (int i = 0; i < 40; i++) push_cmd(CMD_REINSERT, 4'd0, 1'b0);
        for (int i = 0; i < 20; i++) push_cmd(CMD_DISPATCH, 4'd0, 1'b0);
        drain();

        $display("Checked %0d results over slices 2, 0, 15, 1 and a random one.",
                 n_checked);
        $display("Kinds seen: ins %0d fin %0d blk %0d reins %0d empty %0d full %0d lost %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
                 kind_seen[5], kind_seen[6]);
        if (n_err == 0) begin
            $display("shortest_job_first_scheduler_tb passed");
        end else begin
            $display("%0d mismatches", n_err);
            $display("shortest_job_first_scheduler_tb failed");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("Timeout");
        $display("shortest_job_first_scheduler_tb failed");
        $finish;
    end
endmodule
